/* src/buffer_component_to_float32_assert.svh */
// assertion helpers, expect clk and arst_n in scope
`ifndef BUFFER_COMPONENT_TO_FLOAT32_ASSERT_SVH
`define BUFFER_COMPONENT_TO_FLOAT32_ASSERT_SVH

// same-cycle implication
`define BCTF_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bctf assertion failed");

// next-cycle implication
`define BCTF_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bctf assertion failed");

`endif

/* src/bctf_pkg.sv */
package bctf_pkg;

	localparam logic [2:0] ACT_UINT    = 3'd0;
	localparam logic [2:0] ACT_SINT    = 3'd1;
	localparam logic [2:0] ACT_USCALED = 3'd2;
	localparam logic [2:0] ACT_SSCALED = 3'd3;
	localparam logic [2:0] ACT_UNORM   = 3'd4;
	localparam logic [2:0] ACT_SNORM   = 3'd5;
	localparam logic [2:0] ACT_FLOAT   = 3'd6;
	localparam logic [2:0] ACT_OTHER   = 3'd7;

	localparam logic [5:0] WIDTH_SMALL11  = 6'd11;
	localparam logic [5:0] WIDTH_HALF     = 6'd16;
	localparam logic [5:0] WIDTH_FULL     = 6'd32;
	localparam logic [5:0] NORM_MAX_WIDTH = 6'd24;

	localparam logic [4:0]  SMALL_EXP_ONES = 5'h1f;
	localparam logic [7:0]  EXP_REBIAS     = 8'd112;
	localparam logic [7:0]  EXP_ONES       = 8'hff;
	localparam logic [31:0] ONE_BITS       = 32'h3f80_0000;
	localparam logic [31:0] NEG_ONE_BITS   = 32'hbf80_0000;

	// quotient bits of the normalized divide and how they are spread over stages
	localparam int DIV_STEPS     = 27;
	localparam int DIV_PER_STAGE = 3;
	localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

	typedef enum logic [1:0] {
		MODE_DIRECT,
		MODE_SCALED,
		MODE_UNORM,
		MODE_SNORM
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic        neg;
		logic        flag;
		logic [31:0] direct;
		logic [7:0]  expo;
		logic [4:0]  nbits;
	} side_t;

	typedef struct packed {
		logic [31:0] mag;
		logic [31:0] dd;
		side_t       side;
	} front_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [26:0] quo;
		logic [31:0] dd;
		side_t       side;
	} div_t;

endpackage

/* src/buffer_component_to_float32.sv */
// Converts one buffer or vertex component per clock into 32 result bits:
// integer types pass through, scaled types become IEEE singles, normalized
// types are divided by their maximum code with round to nearest even, and
// half and small unsigned floats are widened exactly. The pipeline is 14
// register stages deep, and one word enters every cycle unless in_stall is
// high. The depth is set by the normalized divide, which runs 27 quotient
// bits at 3 bits per stage over 9 stages, after decode, leading-zero count,
// shift and round stages.
// in_stall rises only when every stage holds a word and the output is stalled.
`include "buffer_component_to_float32_assert.svh"

module buffer_component_to_float32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [5:0]  comp_width,
	input  logic [31:0] raw_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits,
	output logic        unsupported_width
);

	localparam int ST_S1     = 0;
	localparam int ST_S2     = 1;
	localparam int ST_S3     = 2;
	localparam int ST_S4     = 3;
	localparam int DIV_FIRST = 4;
	localparam int DIV_LAST  = DIV_FIRST + bctf_pkg::DIV_STAGES - 1;
	localparam int ST_OUT    = DIV_LAST + 1;
	localparam int NUM_ST    = ST_OUT + 1;

	logic [NUM_ST-1:0] vld_q;
	logic [NUM_ST-1:0] rdy;

	bctf_pkg::front_t front_d;
	bctf_pkg::front_t front_s1;
	bctf_pkg::front_t front_s2;
	logic [4:0]       lz_s2;
	bctf_pkg::front_t norm_d;
	bctf_pkg::front_t front_s3;
	logic [4:0]       lz_s3;
	bctf_pkg::div_t   div_d;
	bctf_pkg::div_t   div_s4;
	bctf_pkg::div_t   chain [bctf_pkg::DIV_STAGES+1];
	logic [31:0]      res_s5;
	logic             flag_s5;

	logic        in_neg;
	logic [4:0]  lz_d;
	logic [23:0] r_mant;
	logic        r_inc;
	logic [24:0] r_sum;
	logic [23:0] r_m;
	logic [7:0]  r_exp;
	logic [8:0]  r_base;

	bctf_pkg::div_t fin;
	logic [23:0]    f_mant;
	logic           f_guard;
	logic           f_sticky;
	logic [8:0]     f_exp;
	logic [24:0]    f_sum;
	logic [22:0]    f_frac;
	logic [31:0]    f_q;
	logic [31:0]    res_d;

	// exact single for a small subnormal mantissa times 2^(base-127)
	function automatic logic [30:0] sub_to_single(input logic [9:0] m, input logic [7:0] base);
		logic [3:0]  h;
		logic [23:0] sh;
		h = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				h = 4'(i);
			end
		end
		sh = {14'd0, m} << (5'd23 - {1'b0, h});
		return {8'(base + {4'd0, h}), sh[22:0]};
	endfunction

	function automatic logic [31:0] float_decode(input logic [31:0] raw, input logic [5:0] w);
		logic [4:0]  ex;
		logic [9:0]  m;
		logic [22:0] frac;
		logic [7:0]  base;
		logic [31:0] r;
		if (w == bctf_pkg::WIDTH_FULL) begin
			r = raw;
		end else if (w == bctf_pkg::WIDTH_HALF) begin
			ex = raw[14:10];
			m  = raw[9:0];
			if (ex == bctf_pkg::SMALL_EXP_ONES) begin
				r = {raw[15], bctf_pkg::EXP_ONES, m, 13'd0};
			end else if (ex == 5'd0) begin
				r = (m == 10'd0) ? {raw[15], 31'd0} : {raw[15], sub_to_single(m, 8'd103)};
			end else begin
				r = {raw[15], {3'd0, ex} + bctf_pkg::EXP_REBIAS, m, 13'd0};
			end
		end else begin
			if (w == bctf_pkg::WIDTH_SMALL11) begin
				m    = {4'd0, raw[5:0]};
				ex   = raw[10:6];
				frac = {raw[5:0], 17'd0};
				base = 8'd107;
			end else begin
				m    = {5'd0, raw[4:0]};
				ex   = raw[9:5];
				frac = {raw[4:0], 18'd0};
				base = 8'd108;
			end
			if (ex == bctf_pkg::SMALL_EXP_ONES) begin
				r = {1'b0, bctf_pkg::EXP_ONES, frac};
			end else if (ex == 5'd0) begin
				r = (m == 10'd0) ? 32'd0 : {1'b0, sub_to_single(m, base)};
			end else begin
				r = {1'b0, {3'd0, ex} + bctf_pkg::EXP_REBIAS, frac};
			end
		end
		return r;
	endfunction

	// handshake: a stage loads when it is empty or its word moves on
	assign rdy[ST_OUT] = !vld_q[ST_OUT] || !out_stall;
	genvar k;
	generate
		for (k = 0; k < ST_OUT; k++) begin : g_rdy
			assign rdy[k] = !vld_q[k] || rdy[k+1];
		end
	endgenerate

	assign in_stall = !rdy[ST_S1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_ST; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// stage 1: decode, magnitude, divisor, direct results
	always_comb begin
		in_neg = raw_value[31] &&
			(action == bctf_pkg::ACT_SSCALED || action == bctf_pkg::ACT_SNORM);
		front_d.mag         = in_neg ? 32'(~raw_value + 32'd1) : raw_value;
		front_d.side.mode   = bctf_pkg::MODE_DIRECT;
		front_d.side.neg    = in_neg;
		front_d.side.flag   = 1'b0;
		front_d.side.direct = raw_value;
		front_d.side.expo   = 8'd0;
		front_d.side.nbits  = 5'd1;
		case (action)
			bctf_pkg::ACT_USCALED, bctf_pkg::ACT_SSCALED: begin
				if (raw_value == 32'd0) begin
					front_d.side.direct = 32'd0;
				end else begin
					front_d.side.mode = bctf_pkg::MODE_SCALED;
				end
			end
			bctf_pkg::ACT_UNORM: begin
				if (comp_width < 6'd1 || comp_width > bctf_pkg::NORM_MAX_WIDTH) begin
					front_d.side.flag = 1'b1;
				end else if (raw_value != 32'd0) begin
					front_d.side.mode  = bctf_pkg::MODE_UNORM;
					front_d.side.nbits = comp_width[4:0];
				end
			end
			bctf_pkg::ACT_SNORM: begin
				if (comp_width < 6'd2 || comp_width > bctf_pkg::NORM_MAX_WIDTH) begin
					front_d.side.flag = 1'b1;
				end else if (raw_value != 32'd0) begin
					front_d.side.mode  = bctf_pkg::MODE_SNORM;
					front_d.side.nbits = 5'(comp_width - 6'd1);
				end
			end
			bctf_pkg::ACT_FLOAT: begin
				front_d.side.direct = float_decode(raw_value, comp_width);
			end
			default: begin
				front_d.side.direct = raw_value;
			end
		endcase
		// (2^n - 1) left aligned in 32 bits
		front_d.dd = 32'hffff_ffff << (6'd32 - {1'b0, front_d.side.nbits});
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_S1]) begin
			front_s1 <= front_d;
		end
	end

	// stage 2: leading zero count
	always_comb begin
		lz_d = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (front_s1.mag[i]) begin
				lz_d = 5'(31 - i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_S2]) begin
			front_s2 <= front_s1;
			lz_s2    <= lz_d;
		end
	end

	// stage 3: normalize
	always_comb begin
		norm_d     = front_s2;
		norm_d.mag = front_s2.mag << lz_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_S3]) begin
			front_s3 <= norm_d;
			lz_s3    <= lz_s2;
		end
	end

	// stage 4: round to single, finish scaled, set up the divide
	always_comb begin
		r_mant = front_s3.mag[31:8];
		r_inc  = front_s3.mag[7] && ((|front_s3.mag[6:0]) || r_mant[0]);
		r_sum  = {1'b0, r_mant} + {24'd0, r_inc};
		if (r_sum[24]) begin
			r_m   = 24'h80_0000;
			r_exp = 8'd159 - {3'd0, lz_s3};
		end else begin
			r_m   = r_sum[23:0];
			r_exp = 8'd158 - {3'd0, lz_s3};
		end
		r_base = {1'b0, r_exp} + 9'd1 - {4'd0, front_s3.side.nbits};

		div_d.rem  = {1'b0, r_m, 7'd0};
		div_d.quo  = 27'd0;
		div_d.dd   = front_s3.dd;
		div_d.side = front_s3.side;
		div_d.side.expo = r_base[7:0];
		if (front_s3.side.mode == bctf_pkg::MODE_SCALED) begin
			div_d.side.mode   = bctf_pkg::MODE_DIRECT;
			div_d.side.direct = {front_s3.side.neg, r_exp, r_m[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_S4]) begin
			div_s4 <= div_d;
		end
	end

	assign chain[0] = div_s4;

	genvar g;
	generate
		for (g = 0; g < bctf_pkg::DIV_STAGES; g++) begin : g_div
			bctf_div_stage u_div (
				.clk (clk),
				.en  (rdy[DIV_FIRST+g]),
				.d   (chain[g]),
				.q   (chain[g+1])
			);
		end
	endgenerate

	// last stage: round the quotient, sign and clamp
	always_comb begin
		fin = chain[bctf_pkg::DIV_STAGES];
		if (fin.quo[26]) begin
			f_mant   = fin.quo[26:3];
			f_guard  = fin.quo[2];
			f_sticky = (|fin.quo[1:0]) || (fin.rem != 32'd0);
			f_exp    = {1'b0, fin.side.expo};
		end else begin
			f_mant   = fin.quo[25:2];
			f_guard  = fin.quo[1];
			f_sticky = fin.quo[0] || (fin.rem != 32'd0);
			f_exp    = {1'b0, fin.side.expo} - 9'd1;
		end
		f_sum = {1'b0, f_mant} + {24'd0, f_guard && (f_sticky || f_mant[0])};
		if (f_sum[24]) begin
			f_frac = 23'd0;
			f_exp  = f_exp + 9'd1;
		end else begin
			f_frac = f_sum[22:0];
		end
		f_q = {1'b0, f_exp[7:0], f_frac};
		case (fin.side.mode)
			bctf_pkg::MODE_UNORM: res_d = f_q;
			bctf_pkg::MODE_SNORM: begin
				if (!fin.side.neg) begin
					res_d = f_q;
				end else if (f_q > bctf_pkg::ONE_BITS) begin
					res_d = bctf_pkg::NEG_ONE_BITS;
				end else begin
					res_d = {1'b1, f_q[30:0]};
				end
			end
			default: res_d = fin.side.direct;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_OUT]) begin
			res_s5  <= res_d;
			flag_s5 <= fin.side.flag;
		end
	end

	assign out_valid         = vld_q[ST_OUT];
	assign result_bits       = res_s5;
	assign unsupported_width = flag_s5;

	`BCTF_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid && out_stall)
	`BCTF_ASSERT_IMP(a_flag_is_direct, vld_q[ST_S1] && front_s1.side.flag,
		front_s1.side.mode == bctf_pkg::MODE_DIRECT)
	`BCTF_ASSERT_IMP(a_no_scaled_in_div, vld_q[ST_S4],
		div_s4.side.mode != bctf_pkg::MODE_SCALED)
	`BCTF_ASSERT_IMP(a_div_start_norm, vld_q[ST_S4] &&
		(div_s4.side.mode == bctf_pkg::MODE_UNORM || div_s4.side.mode == bctf_pkg::MODE_SNORM),
		div_s4.rem[30])
	`BCTF_ASSERT_IMP(a_rem_below_div, vld_q[DIV_LAST] &&
		(fin.side.mode == bctf_pkg::MODE_UNORM || fin.side.mode == bctf_pkg::MODE_SNORM),
		fin.rem < fin.dd)

endmodule

/* src/bctf_div_stage.sv */
module bctf_div_stage (
	input  logic              clk,
	input  logic              en,
	input  bctf_pkg::div_t    d,
	output bctf_pkg::div_t    q
);

	bctf_pkg::div_t div_s1;
	bctf_pkg::div_t nxt;
	logic [32:0]    trial [bctf_pkg::DIV_PER_STAGE];

	// restoring division, one quotient bit per step, remainder stays below dd
	always_comb begin
		nxt = d;
		for (int i = 0; i < bctf_pkg::DIV_PER_STAGE; i++) begin
			trial[i] = {nxt.rem, 1'b0};
			if (trial[i] >= {1'b0, nxt.dd}) begin
				nxt.rem = 32'(trial[i] - {1'b0, nxt.dd});
				nxt.quo = {nxt.quo[25:0], 1'b1};
			end else begin
				nxt.rem = trial[i][31:0];
				nxt.quo = {nxt.quo[25:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1 <= nxt;
		end
	end

	assign q = div_s1;

endmodule

/* tb/bctf_checker.sv */
`timescale 1ns / 100ps

module bctf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  action,
	input  logic [5:0]  comp_width,
	input  logic [31:0] raw_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] result_bits,
	input  logic        unsupported_width,
	output int          pending,
	output int          errors
);

	typedef struct packed {
		logic [31:0] bits;
		logic        flag;
	} conv_word_t;

	conv_word_t expected_words[$];
	int err_cnt = 0;

	function automatic int bit_len(logic [63:0] v);
		int n;
		n = 0;
		while (v != 0) begin
			n++;
			v = v >> 1;
		end
		return n;
	endfunction

	// num/den * 2^p as single bits, round to nearest even
	function automatic logic [31:0] div_round(logic [63:0] num, logic [63:0] den, int p);
		int a, b, drop, e, expo;
		logic [63:0] nn, dd, q, rem, mant;
		logic guard, sticky;
		a = 32 - bit_len(num);
		b = 32 - bit_len(den);
		nn = (num << a) << 26;
		dd = den << b;
		q = nn / dd;
		rem = nn % dd;
		if ((q >> 26) != 0) begin
			drop = 3;
			e = 0;
		end else begin
			drop = 2;
			e = -1;
		end
		mant = q >> drop;
		guard = q[drop - 1];
		sticky = ((q & ((64'd1 << (drop - 1)) - 1)) != 0) || (rem != 0);
		if (guard && (sticky || mant[0]))
			mant++;
		if ((mant >> 24) != 0) begin
			mant = mant >> 1;
			e++;
		end
		expo = b - a + p + e + 127;
		if (expo < 1)
			return 32'd0;
		if (expo > 254)
			return {1'b0, bctf_pkg::EXP_ONES, 23'd0};
		return {1'b0, expo[7:0], mant[22:0]};
	endfunction

	function automatic logic [31:0] norm_div(logic [31:0] fbits, logic [63:0] den);
		return div_round({40'd0, 1'b1, fbits[22:0]}, den, int'(fbits[30:23]) - 150);
	endfunction

	function automatic logic [31:0] widen_half(logic [31:0] raw);
		logic [31:0] sign;
		logic [4:0] ex;
		logic [9:0] mant;
		sign = {raw[15], 31'd0};
		ex = raw[14:10];
		mant = raw[9:0];
		if (ex == bctf_pkg::SMALL_EXP_ONES)
			return sign | {1'b0, bctf_pkg::EXP_ONES, mant, 13'd0};
		if (ex == 0) begin
			if (mant == 0)
				return sign;
			return sign | div_round({54'd0, mant}, 64'd1, -24);
		end
		return sign | {1'b0, 8'(ex) + bctf_pkg::EXP_REBIAS, mant, 13'd0};
	endfunction

	function automatic logic [31:0] widen_small(logic [31:0] raw, logic [5:0] w);
		int mbits;
		logic [31:0] mant, frac;
		logic [4:0] ex;
		mbits = (w == bctf_pkg::WIDTH_SMALL11) ? 6 : 5;
		mant = raw & ((32'd1 << mbits) - 1);
		ex = 5'(raw >> mbits);
		frac = mant << (23 - mbits);
		if (ex == bctf_pkg::SMALL_EXP_ONES)
			return {1'b0, bctf_pkg::EXP_ONES, 23'd0} | frac;
		if (ex == 0) begin
			if (mant == 0)
				return 32'd0;
			return div_round({32'd0, mant}, 64'd1, -14 - mbits);
		end
		return {1'b0, 8'(ex) + bctf_pkg::EXP_REBIAS, 23'd0} | frac;
	endfunction

	function automatic conv_word_t convert(logic [2:0] act, logic [5:0] w, logic [31:0] raw);
		conv_word_t r;
		logic neg;
		logic [63:0] mag;
		logic [31:0] q;
		r.bits = raw;
		r.flag = 1'b0;
		neg = raw[31];
		mag = neg ? {32'd0, ~raw} + 64'd1 : {32'd0, raw};
		case (act)
			bctf_pkg::ACT_USCALED: begin
				r.bits = (raw == 0) ? 32'd0 : div_round({32'd0, raw}, 64'd1, 0);
			end
			bctf_pkg::ACT_SSCALED: begin
				r.bits = (mag == 0) ? 32'd0 : div_round(mag, 64'd1, 0) | {neg, 31'd0};
			end
			bctf_pkg::ACT_UNORM: begin
				if (w < 1 || w > bctf_pkg::NORM_MAX_WIDTH)
					r.flag = 1'b1;
				else if (raw != 0)
					r.bits = norm_div(div_round({32'd0, raw}, 64'd1, 0),
						(64'd1 << w) - 1);
			end
			bctf_pkg::ACT_SNORM: begin
				if (w < 2 || w > bctf_pkg::NORM_MAX_WIDTH) begin
					r.flag = 1'b1;
				end else if (raw != 0) begin
					q = norm_div(div_round(mag, 64'd1, 0), (64'd1 << (w - 1)) - 1);
					if (neg)
						r.bits = (q > bctf_pkg::ONE_BITS) ? bctf_pkg::NEG_ONE_BITS :
							(q | 32'h8000_0000);
					else
						r.bits = q;
				end
			end
			bctf_pkg::ACT_FLOAT: begin
				if (w == bctf_pkg::WIDTH_FULL)
					r.bits = raw;
				else if (w == bctf_pkg::WIDTH_HALF)
					r.bits = widen_half(raw);
				else
					r.bits = widen_small(raw, w);
			end
			default: r.bits = raw;
		endcase
		return r;
	endfunction

	assign pending = expected_words.size();
	assign errors  = err_cnt;

	always @(posedge clk) begin
		conv_word_t exp_w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_words.push_back(convert(action, comp_width, raw_value));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word: expected none, actual %h/%b",
						$time, result_bits, unsupported_width);
					err_cnt++;
				end else begin
					exp_w = expected_words.pop_front();
					if (result_bits !== exp_w.bits) begin
						$display("%0t: result_bits mismatch: expected %h, actual %h",
							$time, exp_w.bits, result_bits);
						err_cnt++;
					end
					if (unsupported_width !== exp_w.flag) begin
						$display("%0t: unsupported_width mismatch: expected %b, actual %b",
							$time, exp_w.flag, unsupported_width);
						err_cnt++;
					end
				end
			end
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_WORDS   = 850;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = bctf_pkg::ACT_UINT;
	logic [5:0]  comp_width = 6'd0;
	logic [31:0] raw_value = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result_bits;
	logic        unsupported_width;
	int          pending, errors;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          long_hold_req = 1'b0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	buffer_component_to_float32 dut (.*);

	bctf_checker checker_i (.*);

	// receiver side, with a single long hold-off to fill the pipeline
	initial begin
		int hold;
		bit hold_taken;
		hold = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_word(logic [2:0] a, logic [5:0] w, logic [31:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		comp_width <= w;
		raw_value <= r;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic [2:0] a;
		logic [5:0] w;
		logic [31:0] r;
		a = 3'($urandom_range(7));
		w = 6'($urandom_range(63));
		r = $urandom;
		case (a)
			bctf_pkg::ACT_UNORM, bctf_pkg::ACT_SNORM: begin
				if ($urandom_range(9) != 0)
					w = 6'($urandom_range(24, 1));
				if (w >= 1 && w <= 24 && $urandom_range(3) != 0) begin
					r = r & ((32'd1 << w) - 1);
					// sign extend snorm codes
					if (a == bctf_pkg::ACT_SNORM && r[w - 1])
						r = r | ~((32'd1 << w) - 1);
				end
			end
			bctf_pkg::ACT_FLOAT: begin
				case ($urandom_range(4))
					0: w = bctf_pkg::WIDTH_FULL;
					1: w = bctf_pkg::WIDTH_HALF;
					2: w = bctf_pkg::WIDTH_SMALL11;
					3: w = 6'd10;
					default: ;
				endcase
				if ($urandom_range(3) == 0)
					r = r & 32'h0000_ffff;
			end
			default: if ($urandom_range(3) == 0) r = r >> $urandom_range(31);
		endcase
		send_word(a, w, r);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(bctf_pkg::ACT_UINT, 6'd32, 32'hffff_ffff);
		send_word(bctf_pkg::ACT_SINT, 6'd32, 32'h8000_0000);
		send_word(bctf_pkg::ACT_OTHER, 6'd63, 32'h1234_5678);
		send_word(bctf_pkg::ACT_USCALED, 6'd32, 32'd0);
		send_word(bctf_pkg::ACT_USCALED, 6'd32, 32'hffff_ffff);
		send_word(bctf_pkg::ACT_USCALED, 6'd32, 32'h0100_0003);
		send_word(bctf_pkg::ACT_SSCALED, 6'd32, 32'h8000_0000);
		send_word(bctf_pkg::ACT_SSCALED, 6'd32, 32'hffff_ffff);
		send_word(bctf_pkg::ACT_UNORM, 6'd1, 32'd1);
		send_word(bctf_pkg::ACT_UNORM, 6'd24, 32'h00ff_ffff);
		send_word(bctf_pkg::ACT_UNORM, 6'd0, 32'd5);
		send_word(bctf_pkg::ACT_UNORM, 6'd25, 32'd5);
		send_word(bctf_pkg::ACT_UNORM, 6'd8, 32'd300);
		send_word(bctf_pkg::ACT_SNORM, 6'd1, 32'd1);
		send_word(bctf_pkg::ACT_SNORM, 6'd2, 32'hffff_fffe);
		send_word(bctf_pkg::ACT_SNORM, 6'd16, 32'hffff_8000);
		send_word(bctf_pkg::ACT_SNORM, 6'd16, 32'h0000_7fff);
		send_word(bctf_pkg::ACT_SNORM, 6'd8, 32'd0);
		send_word(bctf_pkg::ACT_FLOAT, 6'd32, 32'hdead_beef);
		send_word(bctf_pkg::ACT_FLOAT, 6'd16, 32'h0000_7c01);
		send_word(bctf_pkg::ACT_FLOAT, 6'd16, 32'hffff_fc00);
		send_word(bctf_pkg::ACT_FLOAT, 6'd16, 32'h0000_8001);
		send_word(bctf_pkg::ACT_FLOAT, 6'd11, 32'h0000_07c1);
		send_word(bctf_pkg::ACT_FLOAT, 6'd11, 32'h0000_003f);
		send_word(bctf_pkg::ACT_FLOAT, 6'd10, 32'h0000_03e1);
		send_word(bctf_pkg::ACT_FLOAT, 6'd7, 32'hffff_ff9f);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  long_hold_req = 1'b1; end
				1: begin send_idle_pct = 77; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 77; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			for (int i = 0; i < RANDOM_WORDS / 4; i++)
				send_random();
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
